### hw/rtl/atbh_pkg.sv
package atbh_pkg;

   // Field widths fixed by the interface
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned COL_W   = 8;
   localparam int unsigned LINE_W  = 8;
   localparam int unsigned STYLE_W = 7;
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned LCNT_W  = 9;
   localparam int unsigned CSR_AW  = 3;
   localparam int unsigned CSR_DW  = 32;

   localparam int unsigned MAX_LINES_DEFAULT = 256;

   // Register reset values
   localparam logic [COL_W-1:0]  WIDTH_CHARS_RESET = 8'd106;
   localparam logic [LCNT_W-1:0] TOTAL_LINES_RESET = 9'd48;

   // Register indexes (byte address bit 2)
   localparam logic REG_WIDTH_CHARS = 1'b0;
   localparam logic REG_TOTAL_LINES = 1'b1;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_ESC       = 8'h1b;
   localparam logic [CHAR_W-1:0] CHAR_LBRACKET  = 8'h5b;
   localparam logic [CHAR_W-1:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [CHAR_W-1:0] CHAR_SGR_END   = 8'h6d;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE      = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI  = 8'h7e;

   // Style bits: [2:0] fg, [3] bold, [6:4] bg
   localparam logic [STYLE_W-1:0] STYLE_DEFAULT = 7'h07;
   localparam logic [STYLE_W-1:0] STYLE_BOLD    = 7'h08;
   localparam logic [STYLE_W-1:0] STYLE_FG      = 7'h07;
   localparam logic [STYLE_W-1:0] STYLE_BG      = 7'h70;

   // SGR codes
   localparam logic [CODE_W-1:0] SGR_RESET   = 8'd0;
   localparam logic [CODE_W-1:0] SGR_BOLD    = 8'd1;
   localparam logic [CODE_W-1:0] SGR_FG_BASE = 8'd30;
   localparam logic [CODE_W-1:0] SGR_FG_LAST = 8'd37;
   localparam logic [CODE_W-1:0] SGR_BG_BASE = 8'd40;
   localparam logic [CODE_W-1:0] SGR_BG_LAST = 8'd47;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_ESC  = 2'd1,
      ST_CSI  = 2'd2
   } parse_state_type;

   // Style update for one finished SGR code
   function automatic logic [STYLE_W-1:0] apply_code(
      input logic [STYLE_W-1:0] style,
      input logic [CODE_W-1:0]  code
   );
      logic [CODE_W-1:0]  delta;
      logic [STYLE_W-1:0] res;
      delta = '0;
      res   = style;
      if (code == SGR_RESET) begin
         res = STYLE_DEFAULT;
      end else if (code == SGR_BOLD) begin
         res = style | STYLE_BOLD;
      end else if (code inside {[SGR_FG_BASE:SGR_FG_LAST]}) begin
         delta = code - SGR_FG_BASE;
         res   = (style & ~STYLE_FG) | {4'b0, delta[2:0]};
      end else if (code inside {[SGR_BG_BASE:SGR_BG_LAST]}) begin
         delta = code - SGR_BG_BASE;
         res   = (style & ~STYLE_BG) | {delta[2:0], 4'b0};
      end
      return res;
   endfunction

endpackage

### hw/rtl/atbh_parser.sv
// Escape parser with SGR code accumulator and current style.
module atbh_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [atbh_pkg::CHAR_W-1:0]        char_code,
   output logic                               consumed,
   output logic [atbh_pkg::STYLE_W-1:0]       style
);

   atbh_pkg::parse_state_type         state_ff, state_in;
   logic [atbh_pkg::CODE_W-1:0]       acc_ff, acc_in;
   logic [atbh_pkg::STYLE_W-1:0]      style_ff, style_in;
   logic                              is_digit;
   logic [atbh_pkg::CODE_W-1:0]       digit;

   assign is_digit = char_code inside {[atbh_pkg::CHAR_ZERO:atbh_pkg::CHAR_NINE]};
   assign digit    = char_code - atbh_pkg::CHAR_ZERO;

   always_comb begin
      state_in = atbh_pkg::ST_IDLE;
      acc_in   = acc_ff;
      style_in = style_ff;
      consumed = 1'b0;
      case (state_ff)
         atbh_pkg::ST_ESC: begin
            if (char_code == atbh_pkg::CHAR_LBRACKET) begin
               state_in = atbh_pkg::ST_CSI;
               acc_in   = '0;
               consumed = 1'b1;
            end
         end
         atbh_pkg::ST_CSI: begin
            if (is_digit) begin
               // times ten, wrapping at eight bits
               acc_in   = (acc_ff << 3) + (acc_ff << 1) + digit;
               state_in = atbh_pkg::ST_CSI;
               consumed = 1'b1;
            end else if (char_code == atbh_pkg::CHAR_SEMICOLON ||
                         char_code == atbh_pkg::CHAR_SGR_END) begin
               style_in = atbh_pkg::apply_code(style_ff, acc_ff);
               acc_in   = '0;
               consumed = 1'b1;
               state_in = (char_code == atbh_pkg::CHAR_SGR_END) ?
                          atbh_pkg::ST_IDLE : atbh_pkg::ST_CSI;
            end
         end
         default: begin
            if (char_code == atbh_pkg::CHAR_ESC) begin
               state_in = atbh_pkg::ST_ESC;
               consumed = 1'b1;
            end
         end
      endcase
   end

   assign style = style_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atbh_pkg::ST_IDLE;
         acc_ff   <= '0;
         style_ff <= atbh_pkg::STYLE_DEFAULT;
      end else if (step) begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         style_ff <= style_in;
      end
   end

endmodule

### hw/rtl/ansi_terminal_byte_handler_core.sv
// ANSI terminal byte handler: takes one character byte per word on req_ and gives exactly
// one result word on rsp_ for each, in order. ESC '[' <codes separated by ';'> 'm' sets
// the style (0 default white on black, 1 bold, 30-37 fg, 40-47 bg); printable bytes
// 0x20-0x7e report a cell write at the current line and column, and a newline or a write
// into the last column moves to the next line of the circular buffer and reports it as the
// line to clear. Each byte moves from the input register to the result register, and a
// new byte is taken every cycle as long as the result side is not held off; the parser
// and cursor state update together with the result register. Registers: width_chars at
// 0x0, total_lines at 0x4; write them only while no word is in flight.
module ansi_terminal_byte_handler_core #(
   parameter int unsigned MAX_LINES = atbh_pkg::MAX_LINES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // byte input
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [atbh_pkg::CHAR_W-1:0]        req_char_code,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_cell_write,
   output logic [atbh_pkg::LINE_W-1:0]        rsp_write_line,
   output logic [atbh_pkg::COL_W-1:0]         rsp_write_column,
   output logic [atbh_pkg::CHAR_W-1:0]        rsp_write_char,
   output logic [atbh_pkg::STYLE_W-1:0]       rsp_write_style,
   output logic                               rsp_new_line,
   output logic [atbh_pkg::LINE_W-1:0]        rsp_cleared_line,
   output logic                               rsp_consumed_by_escape,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [atbh_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [atbh_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [atbh_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   localparam logic [atbh_pkg::LCNT_W-1:0] LINES_MAX = atbh_pkg::LCNT_W'(MAX_LINES);

   // Configuration registers
   logic [atbh_pkg::COL_W-1:0]   width_chars_ff;
   logic [atbh_pkg::LCNT_W-1:0]  total_lines_ff;
   logic                         csr_wr;

   // Input register
   logic                         in_valid_ff;
   logic [atbh_pkg::CHAR_W-1:0]  in_char_ff;
   logic                         advance;

   // Cursor state
   logic [atbh_pkg::COL_W-1:0]   cursor_col_ff, cursor_col_in;
   logic [atbh_pkg::LINE_W-1:0]  end_line_ff, end_line_in;

   // Result register
   logic                         rsp_valid_ff;
   logic                         cell_write_ff, cell_write_in;
   logic [atbh_pkg::LINE_W-1:0]  write_line_ff, write_line_in;
   logic [atbh_pkg::COL_W-1:0]   write_column_ff, write_column_in;
   logic [atbh_pkg::CHAR_W-1:0]  write_char_ff, write_char_in;
   logic [atbh_pkg::STYLE_W-1:0] write_style_ff, write_style_in;
   logic                         new_line_ff, new_line_in;
   logic [atbh_pkg::LINE_W-1:0]  cleared_line_ff, cleared_line_in;
   logic                         consumed_ff;

   // Parser outputs
   logic                         consumed;
   logic [atbh_pkg::STYLE_W-1:0] style;

   // Line wrap helpers
   logic [atbh_pkg::LCNT_W-1:0]  lines_eff;
   logic [atbh_pkg::LCNT_W-1:0]  line_plus;
   logic [atbh_pkg::LINE_W-1:0]  next_line;
   logic [atbh_pkg::COL_W:0]     col_plus;
   logic                         printable;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_chars_ff <= atbh_pkg::WIDTH_CHARS_RESET;
         total_lines_ff <= atbh_pkg::TOTAL_LINES_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            atbh_pkg::REG_WIDTH_CHARS: width_chars_ff <= csr_pwdata[atbh_pkg::COL_W-1:0];
            atbh_pkg::REG_TOTAL_LINES: total_lines_ff <= csr_pwdata[atbh_pkg::LCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         atbh_pkg::REG_WIDTH_CHARS:
            csr_prdata = {{(atbh_pkg::CSR_DW-atbh_pkg::COL_W){1'b0}}, width_chars_ff};
         atbh_pkg::REG_TOTAL_LINES:
            csr_prdata = {{(atbh_pkg::CSR_DW-atbh_pkg::LCNT_W){1'b0}}, total_lines_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // Advance the held byte into the result register whenever that register is
   // empty or being drained; take a new byte whenever the input register is empty or moves.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_code;
      end
   end

   // ---------------------------------------------------------------- parser
   atbh_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_code (in_char_ff),
      .consumed  (consumed),
      .style     (style)
   );

   // ---------------------------------------------------------------- cursor
   // Clamp the line count into 1..MAX_LINES, then wrap the line index.
   always_comb begin
      if (total_lines_ff == '0) begin
         lines_eff = atbh_pkg::LCNT_W'(1);
      end else if (total_lines_ff > LINES_MAX) begin
         lines_eff = LINES_MAX;
      end else begin
         lines_eff = total_lines_ff;
      end
      line_plus = {1'b0, end_line_ff} + atbh_pkg::LCNT_W'(1);
      next_line = (line_plus >= lines_eff) ? '0 : line_plus[atbh_pkg::LINE_W-1:0];
      col_plus  = {1'b0, cursor_col_ff} + (atbh_pkg::COL_W+1)'(1);
   end

   assign printable = in_char_ff inside {[atbh_pkg::CHAR_PRINT_LO:atbh_pkg::CHAR_PRINT_HI]};

   always_comb begin
      cursor_col_in   = cursor_col_ff;
      end_line_in     = end_line_ff;
      cell_write_in   = 1'b0;
      write_line_in   = '0;
      write_column_in = '0;
      write_char_in   = '0;
      write_style_in  = '0;
      new_line_in     = 1'b0;
      cleared_line_in = '0;
      if (!consumed) begin
         if (in_char_ff == atbh_pkg::CHAR_NEWLINE) begin
            end_line_in     = next_line;
            cursor_col_in   = '0;
            new_line_in     = 1'b1;
            cleared_line_in = next_line;
         end else if (printable) begin
            cell_write_in   = 1'b1;
            write_line_in   = end_line_ff;
            write_column_in = cursor_col_ff;
            write_char_in   = in_char_ff;
            write_style_in  = style;
            // last column (or a width shrunk below the cursor): wrap to a fresh line
            if (col_plus >= {1'b0, width_chars_ff}) begin
               end_line_in     = next_line;
               cursor_col_in   = '0;
               new_line_in     = 1'b1;
               cleared_line_in = next_line;
            end else begin
               cursor_col_in = col_plus[atbh_pkg::COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         end_line_ff   <= '0;
      end else if (advance) begin
         cursor_col_ff <= cursor_col_in;
         end_line_ff   <= end_line_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_write_ff   <= cell_write_in;
         write_line_ff   <= write_line_in;
         write_column_ff <= write_column_in;
         write_char_ff   <= write_char_in;
         write_style_ff  <= write_style_in;
         new_line_ff     <= new_line_in;
         cleared_line_ff <= cleared_line_in;
         consumed_ff     <= consumed;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_cell_write         = cell_write_ff;
   assign rsp_write_line         = write_line_ff;
   assign rsp_write_column       = write_column_ff;
   assign rsp_write_char         = write_char_ff;
   assign rsp_write_style        = write_style_ff;
   assign rsp_new_line           = new_line_ff;
   assign rsp_cleared_line       = cleared_line_ff;
   assign rsp_consumed_by_escape = consumed_ff;

   // ---------------------------------------------------------------- checks
   // A byte taken by the escape parser never writes a cell or moves the line.
   a_escape_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && consumed_ff |-> !cell_write_ff && !new_line_ff)
      else $error("escape word also wrote a cell or moved the line");

   // A fresh line leaves the cursor at column zero on the reported line.
   a_new_line_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && new_line_ff |-> cursor_col_ff == '0 && end_line_ff == cleared_line_ff)
      else $error("cursor does not match reported new line");

   // A write without a line move leaves the cursor one column further on the same line.
   a_write_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cell_write_ff && !new_line_ff |->
         cursor_col_ff == write_column_ff + atbh_pkg::COL_W'(1) &&
         end_line_ff == write_line_ff)
      else $error("cursor did not advance after a cell write");

   // Every byte moved forward shows up as a result in the next cycle.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word produced no result");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic                         cell_write;
   logic [atbh_pkg::LINE_W-1:0]  line;
   logic [atbh_pkg::COL_W-1:0]   column;
   logic [atbh_pkg::CHAR_W-1:0]  ch;
   logic [atbh_pkg::STYLE_W-1:0] style;
   logic                         new_line;
   logic [atbh_pkg::LINE_W-1:0]  cleared;
   logic                         escaped;
} cell_result_type;

class sgr_scoreboard_type;
   logic [atbh_pkg::COL_W-1:0]   width_chars;
   logic [atbh_pkg::LCNT_W-1:0]  total_lines;
   atbh_pkg::parse_state_type    parse_state;
   logic [atbh_pkg::CODE_W-1:0]  code_acc;
   logic [atbh_pkg::STYLE_W-1:0] active_style;
   logic [atbh_pkg::COL_W-1:0]   cursor_col;
   logic [atbh_pkg::LINE_W-1:0]  end_line;

   cell_result_type pending_results[$];
   int unsigned     mismatches;
   int unsigned     bytes_seen;
   int unsigned     cell_writes;
   int unsigned     line_advances;
   int unsigned     escape_bytes;

   function new();
      width_chars  = atbh_pkg::WIDTH_CHARS_RESET;
      total_lines  = atbh_pkg::TOTAL_LINES_RESET;
      parse_state  = atbh_pkg::ST_IDLE;
      code_acc     = '0;
      active_style = atbh_pkg::STYLE_DEFAULT;
      cursor_col   = '0;
      end_line     = '0;
   endfunction

   function void set_register(logic idx, logic [atbh_pkg::CSR_DW-1:0] value);
      if (idx == atbh_pkg::REG_WIDTH_CHARS) begin
         width_chars = value[atbh_pkg::COL_W-1:0];
      end else begin
         total_lines = value[atbh_pkg::LCNT_W-1:0];
      end
   endfunction

   function logic [atbh_pkg::STYLE_W-1:0] styled(logic [atbh_pkg::STYLE_W-1:0] s,
                                                 logic [atbh_pkg::CODE_W-1:0] code);
      logic [atbh_pkg::CODE_W-1:0] offset;
      offset = '0;
      if (code == atbh_pkg::SGR_RESET) begin
         return atbh_pkg::STYLE_DEFAULT;
      end else if (code == atbh_pkg::SGR_BOLD) begin
         return s | atbh_pkg::STYLE_BOLD;
      end else if (code >= atbh_pkg::SGR_FG_BASE && code <= atbh_pkg::SGR_FG_LAST) begin
         offset = code - atbh_pkg::SGR_FG_BASE;
         return {s[6:3], offset[2:0]};
      end else if (code >= atbh_pkg::SGR_BG_BASE && code <= atbh_pkg::SGR_BG_LAST) begin
         offset = code - atbh_pkg::SGR_BG_BASE;
         return {offset[2:0], s[3:0]};
      end
      return s;
   endfunction

   // Zero lines acts as one, more than the buffer holds saturates.
   function void next_line();
      int unsigned lines;
      lines = 32'(total_lines);
      if (lines == 0) lines = 1;
      if (lines > atbh_pkg::MAX_LINES_DEFAULT) lines = atbh_pkg::MAX_LINES_DEFAULT;
      end_line   = (int'(end_line) + 1 >= lines) ? '0 : end_line + 1'b1;
      cursor_col = '0;
   endfunction

   function void note_byte(logic [atbh_pkg::CHAR_W-1:0] c);
      cell_result_type r;
      bit              taken;
      r     = '0;
      taken = 1'b0;
      case (parse_state)
         atbh_pkg::ST_ESC: begin
            if (c == atbh_pkg::CHAR_LBRACKET) begin
               parse_state = atbh_pkg::ST_CSI;
               code_acc    = '0;
               taken       = 1'b1;
            end else begin
               parse_state = atbh_pkg::ST_IDLE;
            end
         end
         atbh_pkg::ST_CSI: begin
            if (c >= atbh_pkg::CHAR_ZERO && c <= atbh_pkg::CHAR_NINE) begin
               code_acc = atbh_pkg::CODE_W'(code_acc * 10 + (c - atbh_pkg::CHAR_ZERO));
               taken    = 1'b1;
            end else if (c == atbh_pkg::CHAR_SEMICOLON || c == atbh_pkg::CHAR_SGR_END) begin
               active_style = styled(active_style, code_acc);
               code_acc     = '0;
               if (c == atbh_pkg::CHAR_SGR_END) parse_state = atbh_pkg::ST_IDLE;
               taken = 1'b1;
            end else begin
               parse_state = atbh_pkg::ST_IDLE;
            end
         end
         default: begin
            parse_state = (c == atbh_pkg::CHAR_ESC) ? atbh_pkg::ST_ESC : atbh_pkg::ST_IDLE;
            taken       = (c == atbh_pkg::CHAR_ESC);
         end
      endcase

      if (taken) begin
         r.escaped = 1'b1;
         escape_bytes++;
      end else if (c == atbh_pkg::CHAR_NEWLINE) begin
         next_line();
         r.new_line = 1'b1;
         r.cleared  = end_line;
      end else if (c >= atbh_pkg::CHAR_PRINT_LO && c <= atbh_pkg::CHAR_PRINT_HI) begin
         r.cell_write = 1'b1;
         r.line       = end_line;
         r.column     = cursor_col;
         r.ch         = c;
         r.style      = active_style;
         cell_writes++;
         if (int'(cursor_col) + 1 >= int'(width_chars)) begin
            next_line();
            r.new_line = 1'b1;
            r.cleared  = end_line;
         end else begin
            cursor_col = cursor_col + 1'b1;
         end
      end
      if (r.new_line) line_advances++;
      bytes_seen++;
      pending_results.push_back(r);
   endfunction

   task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH %s", msg);
   endtask

   task check_field(string field, int unsigned got, int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", field, got, want));
      end
   endtask

   task check_result(cell_result_type got);
      cell_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result word with nothing expected");
      end else begin
         want = pending_results.pop_front();
         check_field("cell_write", got.cell_write, want.cell_write);
         check_field("write_line", got.line, want.line);
         check_field("write_column", got.column, want.column);
         check_field("write_char", got.ch, want.ch);
         check_field("write_style", got.style, want.style);
         check_field("new_line", got.new_line, want.new_line);
         check_field("cleared_line", got.cleared, want.cleared);
         check_field("consumed_by_escape", got.escaped, want.escaped);
      end
   endtask

   task flush_leftovers();
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end
   endtask
endclass

module testbench;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 10;
   // phase with idling switched off on both sides, and the one with a random setting
   localparam int QUIET_PHASE  = 3;
   localparam int RANDOM_PHASE = 8;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [atbh_pkg::CHAR_W-1:0]   req_char_code;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_cell_write;
   logic [atbh_pkg::LINE_W-1:0]   rsp_write_line;
   logic [atbh_pkg::COL_W-1:0]    rsp_write_column;
   logic [atbh_pkg::CHAR_W-1:0]   rsp_write_char;
   logic [atbh_pkg::STYLE_W-1:0]  rsp_write_style;
   logic                          rsp_new_line;
   logic [atbh_pkg::LINE_W-1:0]   rsp_cleared_line;
   logic                          rsp_consumed_by_escape;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [atbh_pkg::CSR_AW-1:0]   csr_paddr;
   logic [atbh_pkg::CSR_DW-1:0]   csr_pwdata;
   logic [atbh_pkg::CSR_DW-1:0]   csr_prdata;
   logic                          csr_pready;

   sgr_scoreboard_type board = new();

   int unsigned idle_pct = 16;
   int unsigned items_sent;
   int unsigned settings_run;
   int unsigned stall_count;

   // Settings walked through after the directed part: widths and line counts at both
   // extremes, zero for each, a line count past the buffer size, and small sizes that
   // wrap often. Narrowing right after a wide phase leaves the cursor and the line
   // index beyond the new limits.
   logic [atbh_pkg::COL_W-1:0]  phase_width [PHASES] =
      '{8'd255, 8'd4, 8'd0, 8'd1, 8'd1, 8'd37, 8'd255, 8'd80, 8'd0, 8'd106};
   logic [atbh_pkg::LCNT_W-1:0] phase_lines [PHASES] =
      '{9'd256, 9'd3, 9'd0, 9'd511, 9'd256, 9'd7, 9'd1, 9'd2, 9'd0, 9'd48};
   int unsigned                 phase_items [PHASES] =
      '{120, 80, 60, 300, 250, 150, 80, 80, 120, 60};

   ansi_terminal_byte_handler_core u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Randomly hold off the result side; never when the quiet phase runs.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // Sample both channels on the edge: values seen here are the ones the block saw.
   always @(posedge clock) begin : monitor
      cell_result_type seen;
      if (!reset) begin
         if (req_valid && req_ready) board.note_byte(req_char_code);
         if (rsp_valid && rsp_ready) begin
            seen.cell_write = rsp_cell_write;
            seen.line       = rsp_write_line;
            seen.column     = rsp_write_column;
            seen.ch         = rsp_write_char;
            seen.style      = rsp_write_style;
            seen.new_line   = rsp_new_line;
            seen.cleared    = rsp_cleared_line;
            seen.escaped    = rsp_consumed_by_escape;
            board.check_result(seen);
         end
      end
   end

   // Drop the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Present one byte and hold it until taken; an idle gap comes first at random.
   // Valid stays high across back-to-back words, so it gets one update per edge.
   task automatic send_byte(input logic [atbh_pkg::CHAR_W-1:0] b, input bit counted);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= b;
      do @(posedge clock); while (!req_ready);
      if (counted) items_sent++;
   endtask

   // Emit a decimal number as digit bytes, optionally with a leading zero.
   task automatic send_number(input int unsigned value, input bit pad);
      string digits;
      digits = $sformatf("%0d", value);
      if (pad) digits = {"0", digits};
      for (int i = 0; i < digits.len(); i++) send_byte(digits[i], 1'b1);
   endtask

   // Mostly real style codes; some unknown, some past 255 so the accumulator wraps.
   function automatic int unsigned pick_code();
      int unsigned code;
      case ($urandom_range(9))
         0:       code = atbh_pkg::SGR_RESET;
         1:       code = atbh_pkg::SGR_BOLD;
         2, 3, 4: code = $urandom_range(atbh_pkg::SGR_FG_BASE, atbh_pkg::SGR_FG_LAST);
         5, 6, 7: code = $urandom_range(atbh_pkg::SGR_BG_BASE, atbh_pkg::SGR_BG_LAST);
         8:       code = $urandom_range(255);
         default: code = $urandom_range(256, 999);
      endcase
      return code;
   endfunction

   // A byte that breaks an escape sequence: not '[', not a digit, not ';' or 'm'.
   function automatic logic [atbh_pkg::CHAR_W-1:0] stray_byte();
      logic [atbh_pkg::CHAR_W-1:0] b;
      do begin
         b = atbh_pkg::CHAR_W'($urandom_range(255));
      end while (b == atbh_pkg::CHAR_LBRACKET || b == atbh_pkg::CHAR_SEMICOLON ||
                 b == atbh_pkg::CHAR_SGR_END ||
                 (b >= atbh_pkg::CHAR_ZERO && b <= atbh_pkg::CHAR_NINE));
      return b;
   endfunction

   task automatic send_sgr();
      int unsigned n;
      n = $urandom_range(1, 4);
      send_byte(atbh_pkg::CHAR_ESC, 1'b1);
      send_byte(atbh_pkg::CHAR_LBRACKET, 1'b1);
      for (int k = 0; k < n; k++) begin
         // an empty parameter counts as code zero
         if ($urandom_range(9) != 0) send_number(pick_code(), $urandom_range(7) == 0);
         send_byte((k == n - 1) ? atbh_pkg::CHAR_SGR_END : atbh_pkg::CHAR_SEMICOLON, 1'b1);
      end
   endtask

   // One random chunk: text, newlines, a well-formed style sequence, a broken one,
   // or raw noise.
   task automatic send_chunk();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 40) begin
         repeat ($urandom_range(1, 12))
            send_byte(atbh_pkg::CHAR_W'($urandom_range(atbh_pkg::CHAR_PRINT_LO,
                                                       atbh_pkg::CHAR_PRINT_HI)), 1'b1);
      end else if (kind < 55) begin
         repeat ($urandom_range(1, 3)) send_byte(atbh_pkg::CHAR_NEWLINE, 1'b1);
      end else if (kind < 80) begin
         send_sgr();
      end else if (kind < 90) begin
         send_byte(atbh_pkg::CHAR_ESC, 1'b1);
         if ($urandom_range(1) == 0) begin
            send_byte(atbh_pkg::CHAR_LBRACKET, 1'b1);
            if ($urandom_range(1) == 0) send_number(pick_code(), 1'b0);
         end
         send_byte(stray_byte(), 1'b1);
      end else begin
         repeat ($urandom_range(1, 4))
            send_byte(atbh_pkg::CHAR_W'($urandom_range(255)), 1'b1);
      end
   endtask

   // Setup phase, then access phase, then a return to idle so back-to-back transfers never
   // update the select in the same step.
   task automatic csr_access(input logic idx, input bit wr,
                             input logic [atbh_pkg::CSR_DW-1:0] wdata,
                             output logic [atbh_pkg::CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr) board.set_register(idx, wdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_register(input logic idx, input logic [atbh_pkg::CSR_DW-1:0] want);
      logic [atbh_pkg::CSR_DW-1:0] rd;
      logic [atbh_pkg::CSR_DW-1:0] mask;
      mask = (idx == atbh_pkg::REG_WIDTH_CHARS) ?
             {{(atbh_pkg::CSR_DW-atbh_pkg::COL_W){1'b0}}, {atbh_pkg::COL_W{1'b1}}} :
             {{(atbh_pkg::CSR_DW-atbh_pkg::LCNT_W){1'b0}}, {atbh_pkg::LCNT_W{1'b1}}};
      csr_access(idx, 1'b0, '0, rd);
      if ((rd & mask) != (want & mask)) begin
         board.report_mismatch($sformatf("register %0d read 0x%0h, want 0x%0h",
                                         idx, rd & mask, want & mask));
      end
   endtask

   task automatic configure(input logic [atbh_pkg::COL_W-1:0] w,
                            input logic [atbh_pkg::LCNT_W-1:0] n);
      logic [atbh_pkg::CSR_DW-1:0] unused;
      csr_access(atbh_pkg::REG_WIDTH_CHARS, 1'b1, atbh_pkg::CSR_DW'(w), unused);
      csr_access(atbh_pkg::REG_TOTAL_LINES, 1'b1, atbh_pkg::CSR_DW'(n), unused);
      verify_register(atbh_pkg::REG_WIDTH_CHARS, atbh_pkg::CSR_DW'(w));
      verify_register(atbh_pkg::REG_TOTAL_LINES, atbh_pkg::CSR_DW'(n));
      settings_run++;
   endtask

   // Hold until every expected result is back; each byte gives exactly one.
   // Wait for a clock edge first so the last accepted byte has been noted.
   task automatic drain();
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned target;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_char_code <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values must read back before anything is written.
      verify_register(atbh_pkg::REG_WIDTH_CHARS, atbh_pkg::CSR_DW'(atbh_pkg::WIDTH_CHARS_RESET));
      verify_register(atbh_pkg::REG_TOTAL_LINES, atbh_pkg::CSR_DW'(atbh_pkg::TOTAL_LINES_RESET));
      settings_run = 1;

      // Directed: printable range edges and their neighbors, byte extremes, newline.
      send_byte(atbh_pkg::CHAR_PRINT_LO, 1'b1);
      send_byte(atbh_pkg::CHAR_PRINT_HI, 1'b1);
      send_byte(atbh_pkg::CHAR_PRINT_LO - 1'b1, 1'b1);
      send_byte(atbh_pkg::CHAR_PRINT_HI + 1'b1, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(atbh_pkg::CHAR_NEWLINE, 1'b1);
      // Bold, a foreground and a background in one sequence, then show the style.
      send_byte(atbh_pkg::CHAR_ESC, 1'b1);
      send_byte(atbh_pkg::CHAR_LBRACKET, 1'b1);
      send_number(atbh_pkg::SGR_BOLD, 1'b0);
      send_byte(atbh_pkg::CHAR_SEMICOLON, 1'b1);
      send_number(atbh_pkg::SGR_FG_BASE + 1, 1'b0);
      send_byte(atbh_pkg::CHAR_SEMICOLON, 1'b1);
      send_number(atbh_pkg::SGR_BG_BASE + 4, 1'b0);
      send_byte(atbh_pkg::CHAR_SGR_END, 1'b1);
      send_byte("x", 1'b1);
      // ESC without '[' falls back to an ordinary byte.
      send_byte(atbh_pkg::CHAR_ESC, 1'b1);
      send_byte("Q", 1'b1);
      // A letter inside the parameters abandons the sequence and gets printed.
      send_byte(atbh_pkg::CHAR_ESC, 1'b1);
      send_byte(atbh_pkg::CHAR_LBRACKET, 1'b1);
      send_number($urandom_range(9), 1'b0);
      send_byte("Z", 1'b1);
      req_valid <= 1'b0;

      phase_width[RANDOM_PHASE] = atbh_pkg::COL_W'($urandom_range(255));
      phase_lines[RANDOM_PHASE] = atbh_pkg::LCNT_W'($urandom_range(511));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         configure(phase_width[p], phase_lines[p]);
         idle_pct = (p == QUIET_PHASE) ? 0 : 16;
         target   = items_sent + phase_items[p];
         while (items_sent < target) send_chunk();
         // advance to the next setting only with the stream stopped
         req_valid <= 1'b0;
      end
      idle_pct = 16;

      drain();
      repeat (8) @(posedge clock);
      board.flush_leftovers();

      $display("covered %0d bytes: %0d cell writes, %0d line advances, %0d escape bytes",
               board.bytes_seen, board.cell_writes, board.line_advances, board.escape_bytes);
      $display("over %0d register settings with %0d mismatches",
               settings_run, board.mismatches);
      if (board.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/atbh_pkg.sv
hw/rtl/atbh_parser.sv
hw/rtl/ansi_terminal_byte_handler_core.sv
tb/testbench.sv
